@@ rtl/pnp_pkg.sv @@
`default_nettype none

package pnp_pkg;

    // Geometry
    localparam int PATCH_DIM = 16;
    localparam int MAX_PATCHES_SIDE = 64;
    localparam int CHANNELS = 3;

    // Pixel position inside a patch, 0 .. PATCH_DIM-1
    localparam int PX_W = $clog2(PATCH_DIM);
    // Patch position along one side, 0 .. MAX_PATCHES_SIDE-1
    localparam int SIDE_W = (MAX_PATCHES_SIDE > 1) ? $clog2(MAX_PATCHES_SIDE) : 1;
    // Patch count along one side, 1 .. MAX_PATCHES_SIDE
    localparam int NP_W = $clog2(MAX_PATCHES_SIDE + 1);
    // Product width for the patch index
    localparam int PI_W = SIDE_W + NP_W;

    localparam logic [PX_W-1:0] PX_LAST = PX_W'(PATCH_DIM - 1);

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int PIDX_W = 12;
    localparam int OFFS_W = 10;
    localparam int VALUE_W = 24;
    localparam int SIZE_REG_W = 7;
    localparam int LANE_W = 16;
    localparam int LANES_W = LANE_W * CHANNELS;

    // Arithmetic widths: Q8.12 intermediate, signed difference, signed product
    localparam int X_W = 20;
    localparam int D_W = X_W + 2;
    localparam int P_W = D_W + LANE_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH      = 3'd0,
        CFG_HEIGHT     = 3'd1,
        CFG_RESCALE_EN = 3'd2,
        CFG_NORM_EN    = 3'd3,
        CFG_RESCALE    = 3'd4,
        CFG_MEANS      = 3'd5,
        CFG_INV_STDS   = 3'd6
    } t_cfg_index;

    localparam logic [SIZE_REG_W-1:0] RST_SIDE = 7'd1;
    localparam logic [LANE_W-1:0] RST_RESCALE = 16'd257;
    localparam logic [LANES_W-1:0] RST_MEANS = '0;
    localparam logic [LANES_W-1:0] RST_INV_STDS = {CHANNELS{16'd4096}};

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [PIDX_W-1:0]         patch_index;
        logic [OFFS_W-1:0]         element_offset;
        logic signed [VALUE_W-1:0] value_red;
        logic signed [VALUE_W-1:0] value_green;
        logic signed [VALUE_W-1:0] value_blue;
        logic                      image_done;
    } t_pix_out;

    // Classified item handed from front to back
    typedef struct packed {
        logic [PIDX_W-1:0] patch_index;
        logic [OFFS_W-1:0] element_offset;
        logic              image_done;
        t_pix_in           pix;
    } t_front_item;

    // Image size in patches, already clamped to 1 .. MAX_PATCHES_SIDE
    typedef struct packed {
        logic [NP_W-1:0] wp;
        logic [NP_W-1:0] hp;
    } t_geom;

    typedef struct packed {
        logic               rescale_en;
        logic               norm_en;
        logic [LANE_W-1:0]  scale_mult;
        logic [LANES_W-1:0] means;
        logic [LANES_W-1:0] inv_stds;
    } t_arith;

    // Clamp a size register to 1 .. MAX_PATCHES_SIDE
    function automatic logic [NP_W-1:0] clamp_side(input logic [SIZE_REG_W-1:0] raw);
        logic [NP_W-1:0] v;
        if (raw == '0) begin
            v = NP_W'(1);
        end else if (32'(raw) > MAX_PATCHES_SIDE) begin
            v = NP_W'(MAX_PATCHES_SIDE);
        end else begin
            v = NP_W'(raw);
        end
        return v;
    endfunction

    // Sample to Q8.12, with optional Q0.16 rescale rounded half up
    function automatic logic [X_W-1:0] to_fixed(input logic [SAMPLE_W-1:0] s,
                                                 input logic [LANE_W-1:0] rf,
                                                 input logic en);
        logic [SAMPLE_W+LANE_W-1:0] p;
        logic [X_W-1:0] x;
        p = (SAMPLE_W+LANE_W)'(s) * (SAMPLE_W+LANE_W)'(rf) + (SAMPLE_W+LANE_W)'(8);
        if (en) begin
            x = p[X_W+3:4];
        end else begin
            x = {s, 12'd0};
        end
        return x;
    endfunction

    // Round the Q.24 product half up to Q.12 and saturate to 24 bits
    function automatic logic [VALUE_W-1:0] round_sat(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] s;
        logic [P_W-13:0] q;
        logic [VALUE_W-1:0] y;
        s = p + P_W'(2048);
        q = s[P_W-1:12];
        if (q[P_W-13:VALUE_W-1] == '0 || q[P_W-13:VALUE_W-1] == '1) begin
            y = q[VALUE_W-1:0];
        end else if (q[P_W-13]) begin
            y = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            y = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pnp_front.sv @@
`default_nettype none

module pnp_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_take,
    input  wire pnp_pkg::t_pix_in     i_pix,
    input  wire pnp_pkg::t_geom       i_geom,
    output pnp_pkg::t_front_item      o_item
);
    import pnp_pkg::*;

    logic [SIDE_W-1:0] r_pcol, r_prow, n_pcol, n_prow;
    logic [PX_W-1:0]   r_px, r_py, n_px, n_py;

    logic [SIDE_W-1:0] wm1, hm1, pcol, prow;
    logic [PX_W-1:0]   px, py;
    logic              last_col, done;
    logic [PI_W-1:0]   pidx;
    logic [PIDX_W-1:0] offs;

    // Clamp counters that lie past the image after a size change
    always_comb begin
        wm1 = SIDE_W'(i_geom.wp - NP_W'(1));
        hm1 = SIDE_W'(i_geom.hp - NP_W'(1));
        pcol = r_pcol;
        px   = r_px;
        prow = r_prow;
        py   = r_py;
        if (r_pcol > wm1) begin
            pcol = wm1;
            px   = PX_LAST;
        end
        if (r_prow > hm1) begin
            prow = hm1;
            py   = PX_LAST;
        end
    end

    // Classify the pixel
    always_comb begin
        last_col = (pcol == wm1) && (px == PX_LAST);
        done     = last_col && (prow == hm1) && (py == PX_LAST);
        pidx     = PI_W'(prow) * PI_W'(i_geom.wp) + PI_W'(pcol);
        offs     = (PIDX_W'(py) * PIDX_W'(PATCH_DIM) + PIDX_W'(px)) * PIDX_W'(CHANNELS);
        o_item.patch_index    = PIDX_W'(pidx);
        o_item.element_offset = offs[OFFS_W-1:0];
        o_item.image_done     = done;
        o_item.pix            = i_pix;
    end

    // Advance raster position
    always_comb begin
        n_pcol = pcol;
        n_px   = px;
        n_prow = prow;
        n_py   = py;
        if (last_col) begin
            n_pcol = '0;
            n_px   = '0;
            if (done) begin
                n_prow = '0;
                n_py   = '0;
            end else if (py == PX_LAST) begin
                n_py   = '0;
                n_prow = prow + SIDE_W'(1);
            end else begin
                n_py = py + PX_W'(1);
            end
        end else if (px == PX_LAST) begin
            n_px   = '0;
            n_pcol = pcol + SIDE_W'(1);
        end else begin
            n_px = px + PX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcol <= '0;
            r_px   <= '0;
            r_prow <= '0;
            r_py   <= '0;
        end else if (i_take) begin
            r_pcol <= n_pcol;
            r_px   <= n_px;
            r_prow <= n_prow;
            r_py   <= n_py;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pnp_fifo.sv @@
`default_nettype none

module pnp_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire pnp_pkg::t_front_item i_data,
    output logic                      o_full,
    input  wire logic                 i_rd,
    output logic                      o_empty,
    output pnp_pkg::t_front_item      o_data
);
    import pnp_pkg::*;

    t_front_item           r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  wr_go, rd_go;

    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_go   = i_wr && !o_full;
    assign rd_go   = i_rd && !o_empty;

    // Store incoming beat
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (rd_go) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (wr_go && !rd_go) begin
                r_cnt <= r_cnt + FIFO_CNT_W'(1);
            end else if (rd_go && !wr_go) begin
                r_cnt <= r_cnt - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/pnp_back.sv @@
`default_nettype none

module pnp_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pnp_pkg::t_arith      i_arith,
    input  wire logic                 i_src_empty,
    input  wire pnp_pkg::t_front_item i_src,
    output logic                      o_src_rd,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output pnp_pkg::t_pix_out         o_out
);
    import pnp_pkg::*;

    typedef struct packed {
        logic [PIDX_W-1:0] patch_index;
        logic [OFFS_W-1:0] element_offset;
        logic              image_done;
    } t_meta;

    logic                                r_v1, r_v2, r_v3;
    t_meta                               r_m1, r_m2;
    logic [CHANNELS-1:0][X_W-1:0]        r_x1, r_x2;
    logic signed [CHANNELS-1:0][P_W-1:0] r_p2;
    t_pix_out                            r_out;

    logic                                adv1, adv2, adv3;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]   samp;
    logic [CHANNELS-1:0][X_W-1:0]        n_x1;
    logic signed [CHANNELS-1:0][P_W-1:0] n_p2;
    logic [CHANNELS-1:0][VALUE_W-1:0]    n_y;
    logic signed [D_W-1:0]               d;
    logic [LANE_W-1:0]                   mean, inv;

    // Stage handshakes: a stage moves when the next one is free or moving
    assign adv3     = !r_v3 || i_pop;
    assign adv2     = !r_v2 || adv3;
    assign adv1     = !r_v1 || adv2;
    assign o_src_rd = adv1 && !i_src_empty;
    assign o_empty  = !r_v3;
    assign o_out    = r_out;

    assign samp[0] = i_src.pix.red;
    assign samp[1] = i_src.pix.green;
    assign samp[2] = i_src.pix.blue;

    // Stage 1: rescale to Q8.12
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_x1[c] = to_fixed(samp[c], i_arith.scale_mult, i_arith.rescale_en);
        end
    end

    // Stage 2: subtract mean, scale by reciprocal std
    always_comb begin
        n_p2 = '0;
        d    = '0;
        mean = '0;
        inv  = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            mean    = i_arith.means[c*LANE_W +: LANE_W];
            inv     = i_arith.inv_stds[c*LANE_W +: LANE_W];
            d       = $signed({2'b00, r_x1[c]}) - $signed({{(D_W-LANE_W){mean[LANE_W-1]}}, mean});
            n_p2[c] = P_W'(d) * P_W'($signed({1'b0, inv}));
        end
    end

    // Stage 3: round, saturate or pass through
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_arith.norm_en) begin
                n_y[c] = round_sat(r_p2[c]);
            end else begin
                n_y[c] = VALUE_W'(r_x2[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_m1.patch_index    <= i_src.patch_index;
            r_m1.element_offset <= i_src.element_offset;
            r_m1.image_done     <= i_src.image_done;
            r_x1                <= n_x1;
        end
        if (adv2) begin
            r_m2 <= r_m1;
            r_x2 <= r_x1;
            r_p2 <= n_p2;
        end
        if (adv3) begin
            r_out.patch_index    <= r_m2.patch_index;
            r_out.element_offset <= r_m2.element_offset;
            r_out.image_done     <= r_m2.image_done;
            r_out.value_red      <= n_y[0];
            r_out.value_green    <= n_y[1];
            r_out.value_blue     <= n_y[2];
        end
    end

    // Hold or advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= !i_src_empty;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/pixel_normalize_patchify_core.sv @@
`default_nettype none

// Pixel normalizer and patch classifier.
// Input channel: present one RGB pixel on i_in with i_push high; it is taken at
// a clock edge where o_full is low. Pixels arrive in raster order.
// Result channel: while o_empty is low, o_out holds the oldest result (patch
// index, element offset in the flattened patch, three signed Q11.12 values,
// last-pixel flag); raise i_pop to take it.
// Config channel: i_cfg_index / i_cfg_data are written when i_cfg_valid is
// high; o_cfg_ready is always high. Write only while the block is drained.
// A pixel passes through the queue, the rescale stage, the normalize multiply
// stage and the round/saturate register before its result shows on o_out.
// Throughput: one pixel per cycle while o_full is low; the front-end raster
// counters advance on every pixel taken.
// A stalled receiver fills the three back-end stages and then the four-entry
// queue; o_full rises only after both are full, and nothing is dropped.
// Reset clears the raster position to the first pixel, empties all stages
// and restores the register defaults (1x1 patches, rescale 257, means 0,
// reciprocal stds 1.0, both enables on).
module pixel_normalize_patchify_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire pnp_pkg::t_pix_in              i_in,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output pnp_pkg::t_pix_out                  o_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pnp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pnp_pkg::LANES_W-1:0]   i_cfg_data
);
    import pnp_pkg::*;

    logic [SIZE_REG_W-1:0] r_width, r_height;
    logic                  r_rescale_en, r_norm_en;
    logic [LANE_W-1:0]     r_rescale;
    logic [LANES_W-1:0]    r_means, r_inv_stds;

    t_geom       geom;
    t_arith      arith;
    t_front_item front_item, fifo_item;
    logic        take, fifo_empty, fifo_rd;

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= RST_SIDE;
            r_height     <= RST_SIDE;
            r_rescale_en <= 1'b1;
            r_norm_en    <= 1'b1;
            r_rescale    <= RST_RESCALE;
            r_means      <= RST_MEANS;
            r_inv_stds   <= RST_INV_STDS;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:      r_width      <= i_cfg_data[SIZE_REG_W-1:0];
                CFG_HEIGHT:     r_height     <= i_cfg_data[SIZE_REG_W-1:0];
                CFG_RESCALE_EN: r_rescale_en <= i_cfg_data[0];
                CFG_NORM_EN:    r_norm_en    <= i_cfg_data[0];
                CFG_RESCALE:    r_rescale    <= i_cfg_data[LANE_W-1:0];
                CFG_MEANS:      r_means      <= i_cfg_data;
                CFG_INV_STDS:   r_inv_stds   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        geom.wp          = clamp_side(r_width);
        geom.hp          = clamp_side(r_height);
        arith.rescale_en = r_rescale_en;
        arith.norm_en    = r_norm_en;
        arith.scale_mult = r_rescale;
        arith.means      = r_means;
        arith.inv_stds   = r_inv_stds;
    end

    assign take = i_push && !o_full;

    pnp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_pix   (i_in),
        .i_geom  (geom),
        .o_item  (front_item)
    );

    pnp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (take),
        .i_data  (front_item),
        .o_full  (o_full),
        .i_rd    (fifo_rd),
        .o_empty (fifo_empty),
        .o_data  (fifo_item)
    );

    pnp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_arith     (arith),
        .i_src_empty (fifo_empty),
        .i_src       (fifo_item),
        .o_src_rd    (fifo_rd),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import pnp_pkg::*;

    // Register index past the end of the list; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int RANDOM_PIXELS = 1600;
    localparam int LONG_HOLD = 250;

    typedef enum int {
        POP_ALWAYS,
        POP_MOSTLY,
        POP_RARELY,
        POP_PERIODIC
    } t_pop_mode;

    // Mirror of the block: register file, raster counters, expected beats
    class pixel_scoreboard;
        logic [SIZE_REG_W-1:0] width_reg;
        logic [SIZE_REG_W-1:0] height_reg;
        logic                  rescale_on;
        logic                  norm_on;
        logic [LANE_W-1:0]     scale_mult;
        logic [LANES_W-1:0]    means;
        logic [LANES_W-1:0]    inv_stds;
        int unsigned           col_pos;
        int unsigned           row_pos;
        t_pix_out              expected_q[$];
        int unsigned           mismatches;

        function new();
            width_reg      = RST_SIDE;
            height_reg     = RST_SIDE;
            rescale_on     = 1'b1;
            norm_on        = 1'b1;
            scale_mult     = RST_RESCALE;
            means          = RST_MEANS;
            inv_stds       = RST_INV_STDS;
            col_pos        = 0;
            row_pos        = 0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LANES_W-1:0] data);
            case (idx)
                CFG_WIDTH:      width_reg = data[SIZE_REG_W-1:0];
                CFG_HEIGHT:     height_reg = data[SIZE_REG_W-1:0];
                CFG_RESCALE_EN: rescale_on = data[0];
                CFG_NORM_EN:    norm_on = data[0];
                CFG_RESCALE:    scale_mult = data[LANE_W-1:0];
                CFG_MEANS:      means = data;
                CFG_INV_STDS:   inv_stds = data;
                default: ;
            endcase
        endfunction

        // Zero counts as one patch, anything past the maximum as the maximum
        function int unsigned side_in_patches(logic [SIZE_REG_W-1:0] raw);
            if (raw == '0) return 1;
            if (int'(raw) > MAX_PATCHES_SIDE) return MAX_PATCHES_SIDE;
            return int'(raw);
        endfunction

        function logic signed [VALUE_W-1:0] channel_value(logic [SAMPLE_W-1:0] s, int lane);
            longint x;
            longint y;
            logic [LANE_W-1:0] mean_raw;
            mean_raw = means[lane*LANE_W +: LANE_W];
            // Q8.12 intermediate, rescale product rounded half up
            if (rescale_on) x = (longint'(s) * longint'(scale_mult) + 8) >>> 4;
            else x = longint'(s) << 12;
            // Q.24 product rounded half up to Q.12, floor on negatives
            if (norm_on) begin
                y = (x - longint'($signed(mean_raw)))
                    * longint'(inv_stds[lane*LANE_W +: LANE_W]) + 2048;
                y = y >>> 12;
            end else begin
                y = x;
            end
            if (y > 64'sd8388607) y = 64'sd8388607;
            if (y < -64'sd8388608) y = -64'sd8388608;
            return y[VALUE_W-1:0];
        endfunction

        function void note_pixel(t_pix_in p);
            int unsigned wp;
            int unsigned wpix;
            int unsigned hpix;
            int unsigned col;
            int unsigned row;
            logic        last_col;
            t_pix_out    e;
            wp   = side_in_patches(width_reg);
            wpix = wp * PATCH_DIM;
            hpix = side_in_patches(height_reg) * PATCH_DIM;
            // Pull counters back inside the image if it shrank mid-frame
            col = (col_pos > wpix - 1) ? wpix - 1 : col_pos;
            row = (row_pos > hpix - 1) ? hpix - 1 : row_pos;
            e.patch_index    = PIDX_W'((row / PATCH_DIM) * wp + col / PATCH_DIM);
            e.element_offset = OFFS_W'(((row % PATCH_DIM) * PATCH_DIM
                                        + col % PATCH_DIM) * CHANNELS);
            e.value_red      = channel_value(p.red, 0);
            e.value_green    = channel_value(p.green, 1);
            e.value_blue     = channel_value(p.blue, 2);
            last_col         = (col == wpix - 1);
            e.image_done     = last_col && (row == hpix - 1);
            expected_q.insert(expected_q.size(), e);
            // Advance the raster position
            if (last_col) begin
                col_pos = 0;
                row_pos = e.image_done ? 0 : row + 1;
            end else begin
                col_pos = col + 1;
                row_pos = row;
            end
        endfunction

        function void check_result(t_pix_out got);
            t_pix_out e;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: patch %0d offset %0d rgb %0d %0d %0d done %0b",
                             got.patch_index, got.element_offset, got.value_red,
                             got.value_green, got.value_blue, got.image_done);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (got.patch_index !== e.patch_index || got.element_offset !== e.element_offset
                || got.value_red !== e.value_red || got.value_green !== e.value_green
                || got.value_blue !== e.value_blue || got.image_done !== e.image_done) begin
                if (mismatches < 10) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected patch %0d offset %0d rgb %0d %0d %0d done %0b",
                             e.patch_index, e.element_offset, e.value_red,
                             e.value_green, e.value_blue, e.image_done);
                    $display("  actual   patch %0d offset %0d rgb %0d %0d %0d done %0b",
                             got.patch_index, got.element_offset, got.value_red,
                             got.value_green, got.value_blue, got.image_done);
                end
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function int unsigned failures();
            return mismatches + expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 pix_push;
    logic                 pix_full;
    t_pix_in              pix_in;
    logic                 res_empty;
    logic                 res_pop;
    t_pix_out             res_out;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LANES_W-1:0]   cfg_data;

    pixel_scoreboard sb = new();

    // Hold-off requests from the stimulus side, served by the receiver
    int unsigned hold_requests = 0;
    int unsigned hold_len = 0;
    int unsigned random_pixels = 0;

    pixel_normalize_patchify_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (pix_push),
        .o_full      (pix_full),
        .i_in        (pix_in),
        .o_empty     (res_empty),
        .i_pop       (res_pop),
        .o_out       (res_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [LANES_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Favor one-patch sides so frames complete; hit zero and oversize too
    function automatic logic [SIZE_REG_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 7'd1;
            4:          return 7'd0;
            5:          return 7'd2;
            6:          return 7'($urandom_range(65, 127));
            default:    return 7'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [LANES_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel beat and hold it until the block takes it
    task automatic send_pixel(input t_pix_in p);
        @(negedge clk);
        pix_push <= 1'b1;
        pix_in   <= p;
        do @(posedge clk); while (pix_full);
        sb.note_pixel(p);
    endtask

    // Drop push for a span set by n, with junk on the data lines
    task automatic idle_push(input int n);
        @(negedge clk);
        pix_push <= 1'b0;
        pix_in   <= t_pix_in'(24'($urandom));
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drain();
        idle_push(1);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic request_hold(input int unsigned cycles);
        hold_len = cycles;
        hold_requests++;
    endtask

    task automatic send_stream(input int count, input bit steady);
        int burst_left;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < count; i++) begin
            send_pixel(t_pix_in'(24'($urandom)));
            if (!steady) begin
                burst_left--;
                if (burst_left == 0) begin
                    idle_push($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 40);
                end
            end
        end
    endtask

    // Black, white and alternating bit patterns, back to back
    task automatic send_extremes();
        send_pixel('{8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'hAA, 8'h55, 8'h0F});
        send_pixel('{8'h55, 8'hAA, 8'hF0});
    endtask

    task automatic randomize_config();
        logic [LANES_W-1:0] d;
        if ($urandom_range(0, 2) != 0) begin
            d = rand48();
            d[SIZE_REG_W-1:0] = pick_side();
            write_config(CFG_WIDTH, d);
        end
        if ($urandom_range(0, 2) != 0) begin
            d = rand48();
            d[SIZE_REG_W-1:0] = pick_side();
            write_config(CFG_HEIGHT, d);
        end
        if ($urandom_range(0, 2) == 0) write_config(CFG_RESCALE_EN, rand48());
        if ($urandom_range(0, 2) == 0) write_config(CFG_NORM_EN, rand48());
        if ($urandom_range(0, 2) == 0) begin
            d = rand48();
            case ($urandom_range(0, 3))
                0: d[LANE_W-1:0] = '0;
                1: d[LANE_W-1:0] = '1;
                2: d[LANE_W-1:0] = RST_RESCALE;
                default: ;
            endcase
            write_config(CFG_RESCALE, d);
        end
        if ($urandom_range(0, 2) == 0) begin
            d = rand48();
            case ($urandom_range(0, 4))
                0: d = {CHANNELS{16'h8000}};
                1: d = {CHANNELS{16'h7FFF}};
                default: ;
            endcase
            write_config(CFG_MEANS, d);
        end
        if ($urandom_range(0, 2) == 0) begin
            d = rand48();
            case ($urandom_range(0, 5))
                0: d = '0;
                1: d = '1;
                2: d = RST_INV_STDS;
                default: ;
            endcase
            write_config(CFG_INV_STDS, d);
        end
        if ($urandom_range(0, 7) == 0) write_config(CFG_IDX_SPARE, rand48());
    endtask

    // Receiver: check each result beat, then pick pop for the next cycle
    initial begin
        t_pop_mode   mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned hold_seen;
        logic        pop_next;
        res_pop   = 1'b0;
        mode      = POP_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && res_pop && !res_empty) sb.check_result(res_out);
            @(negedge clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = hold_len;
            end
            if (mode_left == 0) begin
                mode      = t_pop_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop_next = 1'b0;
            end else begin
                case (mode)
                    POP_ALWAYS:   pop_next = 1'b1;
                    POP_MOSTLY:   pop_next = ($urandom_range(0, 3) != 0);
                    POP_RARELY:   pop_next = ($urandom_range(0, 3) == 0);
                    POP_PERIODIC: pop_next = (mode_left % 5 != 0);
                    default:      pop_next = 1'b1;
                endcase
            end
            res_pop <= pop_next;
        end
    end

    // Stimulus
    initial begin
        int n;
        rst_n     = 1'b0;
        pix_push  = 1'b0;
        pix_in    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults straight out of reset
        send_extremes();

        // Raw samples: both stages bypassed
        wait_drain();
        write_config(CFG_RESCALE_EN, 48'd0);
        write_config(CFG_NORM_EN, 48'd0);
        send_extremes();

        // Largest rescale factor, normalize still off
        wait_drain();
        write_config(CFG_RESCALE_EN, 48'd1);
        write_config(CFG_RESCALE, {32'hFFFF_FFFF, 16'hFFFF});
        send_extremes();

        // Most negative mean and largest gain: the brighter samples saturate positive
        wait_drain();
        write_config(CFG_RESCALE_EN, 48'd0);
        write_config(CFG_NORM_EN, 48'd1);
        write_config(CFG_MEANS, {CHANNELS{16'h8000}});
        write_config(CFG_INV_STDS, {CHANNELS{16'hFFFF}});
        send_extremes();

        // Zero rescale with positive mean drives every value negative;
        // size registers at zero and at the top, spare index ignored
        wait_drain();
        write_config(CFG_RESCALE_EN, 48'd1);
        write_config(CFG_RESCALE, 48'd0);
        write_config(CFG_MEANS, {CHANNELS{16'h7FFF}});
        write_config(CFG_WIDTH, 48'd0);
        write_config(CFG_HEIGHT, 48'h7F);
        write_config(CFG_IDX_SPARE, '1);
        send_extremes();

        // Wide image, then shrink the width with the column past the edge
        wait_drain();
        write_config(CFG_RESCALE, 48'(RST_RESCALE));
        write_config(CFG_MEANS, rand48());
        write_config(CFG_INV_STDS, RST_INV_STDS);
        write_config(CFG_WIDTH, 48'd64);
        write_config(CFG_HEIGHT, 48'd2);
        send_stream(150, 1'b0);
        wait_drain();
        write_config(CFG_WIDTH, 48'd1);
        // Long receiver stall while pixels keep coming: fill and back up
        request_hold(LONG_HOLD);
        send_stream(350, 1'b1);
        // Shrink the height with the row past the bottom
        wait_drain();
        write_config(CFG_HEIGHT, 48'd1);
        send_stream(200, 1'b0);
        random_pixels = 700;

        // Random phases, each with its own register settings
        while (random_pixels < RANDOM_PIXELS) begin
            wait_drain();
            randomize_config();
            n = $urandom_range(20, 250);
            if ($urandom_range(0, 4) == 0) request_hold($urandom_range(100, 300));
            send_stream(n, $urandom_range(0, 3) == 0);
            random_pixels += n;
        end

        wait_drain();
        repeat (10) @(negedge clk);
        if (sb.failures() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
